// ----- rtl/core/utt_pkg.sv -----
// Shared types, constants and the BMP encoder of the UTF-16 to UTF-8 transcoder.
`default_nettype none
package utt_pkg;

   localparam int unsigned JOB_BYTES         = 6;
   localparam int unsigned JOB_CNT_W         = 3;
   localparam int unsigned QUEUE_DEPTH_DEF   = 2;

   localparam logic [5:0]  SURR_HIGH_TAG     = 6'b110110;
   localparam logic [5:0]  SURR_LOW_TAG      = 6'b110111;
   localparam logic [20:0] SUPP_PLANE_BASE   = 21'h10000;

   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [JOB_CNT_W-1:0]      count;
   } job_type;

   typedef struct packed {
      logic [2:0][7:0] bytes;
      logic [1:0]      len;
   } bmp_enc_type;

   function automatic bmp_enc_type encode_bmp(input logic [15:0] v);
      bmp_enc_type enc;
      enc = '0;
      if (v < 16'h0080) begin
         enc.bytes[0] = v[7:0];
         enc.len      = 2'd1;
      end else if (v < 16'h0800) begin
         enc.bytes[0] = {3'b110, v[10:6]};
         enc.bytes[1] = {2'b10, v[5:0]};
         enc.len      = 2'd2;
      end else begin
         enc.bytes[0] = {4'b1110, v[15:12]};
         enc.bytes[1] = {2'b10, v[11:6]};
         enc.bytes[2] = {2'b10, v[5:0]};
         enc.len      = 2'd3;
      end
      return enc;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/core/utt_front.sv -----
// Front end: accepts code units, pairs surrogates and builds byte jobs.
`default_nettype none
module utt_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire logic [15:0]     req_tdata,   // [15:0] code_unit
   input  wire logic            req_tlast,   // end_of_text
   input  wire logic            queue_full,
   output logic                 push,
   output utt_pkg::job_type     push_job
);
   import utt_pkg::*;

   logic        held_valid_ff, held_valid_in;
   logic [9:0]  held_bits_ff, held_bits_in;
   logic        accept;
   logic        is_high, is_low, hold_new;
   logic [20:0] cp;
   bmp_enc_type held_enc, unit_enc;
   job_type     job;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign is_high    = (req_tdata[15:10] == SURR_HIGH_TAG);
   assign is_low     = (req_tdata[15:10] == SURR_LOW_TAG);
   assign hold_new   = is_high && !req_tlast;
   assign cp         = {1'b0, held_bits_ff, req_tdata[9:0]} + SUPP_PLANE_BASE;
   assign held_enc   = encode_bmp({SURR_HIGH_TAG, held_bits_ff});
   assign unit_enc   = encode_bmp(req_tdata);

   always_comb begin
      job = '0;
      if (held_valid_ff && is_low) begin
         job.bytes[0] = {5'b11110, cp[20:18]};
         job.bytes[1] = {2'b10, cp[17:12]};
         job.bytes[2] = {2'b10, cp[11:6]};
         job.bytes[3] = {2'b10, cp[5:0]};
         job.count    = JOB_CNT_W'(4);
      end else if (held_valid_ff) begin
         job.bytes[2:0] = held_enc.bytes;
         if (hold_new) begin
            job.count = JOB_CNT_W'(3);
         end else begin
            job.bytes[5:3] = unit_enc.bytes;
            job.count      = JOB_CNT_W'(3) + JOB_CNT_W'(unit_enc.len);
         end
      end else if (!hold_new) begin
         job.bytes[2:0] = unit_enc.bytes;
         job.count      = JOB_CNT_W'(unit_enc.len);
      end
   end

   assign push     = accept && (job.count != '0);
   assign push_job = job;

   always_comb begin
      held_valid_in = held_valid_ff;
      held_bits_in  = held_bits_ff;
      if (accept) begin
         if (hold_new && !(held_valid_ff && is_low)) begin
            held_valid_in = 1'b1;
            held_bits_in  = req_tdata[9:0];
         end else begin
            held_valid_in = 1'b0;
            held_bits_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_bits_ff  <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_bits_ff  <= held_bits_in;
      end
   end

`ifndef SYNTHESIS
   a_pair_clears: assert property (@(posedge clock) disable iff (reset)
      accept && held_valid_ff && is_low |=> !held_valid_ff)
      else $error("pair completion left a surrogate held");
   a_plain_clears: assert property (@(posedge clock) disable iff (reset)
      accept && !hold_new |=> !held_valid_ff)
      else $error("surrogate held after a non-holding word");
   a_pair_len: assert property (@(posedge clock) disable iff (reset)
      push && held_valid_ff && is_low |-> push_job.count == JOB_CNT_W'(4))
      else $error("surrogate pair not four bytes");
   a_held_len: assert property (@(posedge clock) disable iff (reset)
      push && held_valid_ff |-> push_job.count >= JOB_CNT_W'(3))
      else $error("flushed surrogate shorter than three bytes");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/utt_queue.sv -----
// Short job queue between the front end and the byte serialiser.
`default_nettype none
module utt_queue #(
   parameter int unsigned DEPTH = utt_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire utt_pkg::job_type push_job,
   input  wire logic             pop,
   output utt_pkg::job_type      head,
   output logic                  head_valid,
   output logic                  full
);
   import utt_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/utt_back.sv -----
// Back end: serialises queued byte jobs onto the result stream.
`default_nettype none
module utt_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire utt_pkg::job_type head,
   input  wire logic             head_valid,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_byte
   output logic                  rsp_tlast    // last_of_run
);
   import utt_pkg::*;

   logic [JOB_CNT_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           data_ff, data_in;
   logic                 last_ff, last_in;
   logic                 load, at_last;

   assign load    = head_valid && (!valid_ff || rsp_tready);
   assign at_last = (idx_ff == head.count - 1'b1);
   assign pop     = load && at_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = head.bytes[idx_ff];
         last_in  = at_last;
         idx_in   = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// ----- rtl/core/utf16_to_utf8_transcoder.sv -----
// Top level of the UTF-16 to UTF-8 transcoder.
// One code unit is taken per req word (tlast marks end of text) and its UTF-8
// bytes leave one per rsp word, tlast on the last byte a unit causes. The front
// end takes a unit every cycle while the job queue (QUEUE_DEPTH jobs) has room;
// the byte serialiser sets the sustained rate at one byte per cycle while
// rsp_tready is high; a unit makes 1, 2, 3 or 4 bytes by its length, up to 6 when
// a held high surrogate is flushed ahead of it, and none when a high surrogate is
// only held. A byte reaches rsp through the job queue and the output register.
`default_nettype none
module utf16_to_utf8_transcoder #(
   parameter int unsigned QUEUE_DEPTH = utt_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] code_unit
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast    // last_of_run
);
   import utt_pkg::*;

   logic    push, pop, head_valid, queue_full;
   job_type push_job, head;

   utt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   utt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (queue_full)
   );

   utt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the UTF-16 to UTF-8 transcoder: directed and random code units, bytes checked.
module tb;

   localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
   localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
   localparam logic [15:0] SURR_END        = 16'hE000;
   localparam logic [20:0] SUPP_BASE       = 21'h10000;
   localparam int          HOLD_OFF_CYCLES = 400;
   localparam int          RANDOM_UNITS    = 250;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } utf8_word_type;

   class utf8_byte_tracker;
      utf8_word_type expected_utf8[$];
      logic [9:0]    held_bits;
      logic          held_valid;
      int            errors;

      function new();
         held_bits  = '0;
         held_valid = 1'b0;
         errors     = 0;
      endfunction

      function int pending();
         return expected_utf8.size();
      endfunction

      task report(input string msg);
         $display("[%0t] mismatch: %s", $realtime, msg);
         errors++;
      endtask

      function void push_byte(input logic [7:0] b);
         utf8_word_type w;
         w.data = b;
         w.last = 1'b0;
         expected_utf8.push_back(w);
      endfunction

      function void push_bmp(input logic [15:0] v);
         if (v < 16'h0080) begin
            push_byte(v[7:0]);
         end else if (v < 16'h0800) begin
            push_byte(8'hC0 + v[10:6]);
            push_byte(8'h80 + v[5:0]);
         end else begin
            push_byte(8'hE0 + v[15:12]);
            push_byte(8'h80 + v[11:6]);
            push_byte(8'h80 + v[5:0]);
         end
      endfunction

      // predict the bytes caused by one accepted unit
      function void note_unit(input logic [15:0] unit, input logic eot);
         int         first;
         logic [20:0] cp;
         first = expected_utf8.size();
         if (held_valid && unit >= LOW_SURR_FIRST && unit < SURR_END) begin
            cp = {1'b0, held_bits, unit[9:0]} + SUPP_BASE;
            push_byte(8'hF0 + cp[20:18]);
            push_byte(8'h80 + cp[17:12]);
            push_byte(8'h80 + cp[11:6]);
            push_byte(8'h80 + cp[5:0]);
            held_valid = 1'b0;
            held_bits  = '0;
         end else begin
            if (held_valid) begin
               push_bmp(HIGH_SURR_FIRST | {6'b0, held_bits});
               held_valid = 1'b0;
               held_bits  = '0;
            end
            if (unit >= HIGH_SURR_FIRST && unit < LOW_SURR_FIRST && !eot) begin
               held_bits  = unit[9:0];
               held_valid = 1'b1;
            end else begin
               push_bmp(unit);
            end
         end
         if (expected_utf8.size() > first)
            expected_utf8[expected_utf8.size() - 1].last = 1'b1;
      endfunction

      task check_byte(input logic [7:0] data, input logic last);
         utf8_word_type w;
         if (expected_utf8.size() == 0) begin
            report($sformatf("unexpected byte %02h last %0b", data, last));
         end else begin
            w = expected_utf8.pop_front();
            if (data !== w.data)
               report($sformatf("byte %02h, predicted %02h", data, w.data));
            if (last !== w.last)
               report($sformatf("tlast %0b on byte %02h, predicted %0b", last, data, w.last));
         end
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [15:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   utf8_byte_tracker tracker;
   bit steady       = 1'b0;
   bit hold_request = 1'b0;
   int units_sent   = 0;

   utf16_to_utf8_transcoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_unit(input logic [15:0] unit, input logic eot);
      int gap;
      gap = steady ? 0 : idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= unit;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      tracker.note_unit(unit, eot);
      units_sent++;
   endtask

   function automatic logic [15:0] plain_unit();
      if ($urandom_range(0, 1))
         return 16'($urandom_range(16'h0800, 16'hD7FF));
      return 16'($urandom_range(16'hE000, 16'hFFFF));
   endfunction

   task automatic send_sequence();
      int   kind;
      logic [15:0] hi;
      logic eot;
      kind = $urandom_range(0, 11);
      eot  = ($urandom_range(0, 7) == 0);
      hi   = HIGH_SURR_FIRST | 16'($urandom_range(0, 1023));
      case (kind)
         0, 1: begin
            send_unit(16'($urandom_range(0, 16'h007F)), eot);
         end
         2: begin
            send_unit(16'($urandom_range(16'h0080, 16'h07FF)), eot);
         end
         3: begin
            send_unit(plain_unit(), eot);
         end
         4, 5, 6, 7: begin
            send_unit(hi, 1'b0);
            send_unit(LOW_SURR_FIRST | 16'($urandom_range(0, 1023)), eot);
         end
         8: begin
            send_unit(hi, 1'b0);
            send_unit(16'($urandom_range(0, 16'hFFFF)), eot);
         end
         9: begin
            send_unit(LOW_SURR_FIRST | 16'($urandom_range(0, 1023)), eot);
         end
         10: begin
            send_unit(hi, 1'b1);
         end
         default: begin
            send_unit(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
         end
      endcase
   endtask

   task automatic run_random(input int count);
      int target;
      target = units_sent + count;
      while (units_sent < target)
         send_sequence();
   endtask

   task automatic drain();
      while (tracker.pending() != 0)
         @(posedge clock);
   endtask

   initial begin : rsp_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            tracker.check_byte(rsp_tdata, rsp_tlast);
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_OFF_CYCLES;
            rsp_tready  <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            stall_left = steady ? 0 : idle_cycles();
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   initial begin
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // range edges of each length
      send_unit(16'h0000, 1'b0);
      send_unit(16'h007F, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h07FF, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hFFFF, 1'b1);
      send_unit(16'hD7FF, 1'b0);
      send_unit(16'hE000, 1'b0);
      // pairs at both ends of the supplementary range
      send_unit(16'hD800, 1'b0);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'hDFFF, 1'b1);
      // held high surrogate flushed by a non-low unit
      send_unit(16'hD801, 1'b0);
      send_unit(16'h0041, 1'b0);
      // high after high: flush, hold the second, flush again
      send_unit(16'hDA00, 1'b0);
      send_unit(16'hDB00, 1'b0);
      send_unit(16'h07FF, 1'b1);
      // lone low, high at end of text
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDABC, 1'b1);
      // held high, then high at end of text: six bytes
      send_unit(16'hD955, 1'b0);
      send_unit(16'hDBAA, 1'b1);
      send_unit(16'hFFFF, 1'b0);

      run_random(80);
      steady = 1'b1;
      run_random(40);
      steady = 1'b0;
      hold_request = 1'b1;
      run_random(40);
      req_tvalid <= 1'b0;
      drain();
      run_random(RANDOM_UNITS - 160);
      req_tvalid <= 1'b0;

      drain();
      repeat (20) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
